@@ rtl/avcc_nks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_nks_pkg
// shared types and constants of the avcc key-frame scanner
// ----------------------------------------------------------------------------
package avcc_nks_pkg;

    localparam int OFFSET_BITS_DEFAULT = 20;

    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 20;
    localparam int WINDOW_W = 32;

    localparam logic [2:0] PREFIX_BYTES = 3'd4;

    localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;

    // one input word as seen by the scan core
    typedef struct packed {
        logic [LENGTH_W-1:0] frame_length;
        logic                last_byte;
        logic                first_byte;
        logic [BYTE_W-1:0]   data_byte;
    } item_t;

    // one result word, field order matches the master tdata packing
    typedef struct packed {
        logic [LENGTH_W-1:0] sps_offset;
        logic                sps_found;
        logic [LENGTH_W-1:0] remaining_length;
        logic [LENGTH_W-1:0] keyframe_offset;
        logic                keyframe_found;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/avcc_nalu_keyframe_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_nalu_keyframe_scanner
// finds the first idr unit and the last sps before it in an avcc frame
// ----------------------------------------------------------------------------
// usage:
//  the slave channel takes one frame byte per word; tuser marks the frame's
//  first byte (which also carries the frame length), tlast its final byte.
//  the master channel gives one word per frame, on the word that had tlast:
//  idr found flag and offset, remaining length, sps found flag and offset.
//  m_axis_tvalid rises once a tlast word has passed through the input register
//  and loaded the result register; the load waits while the result is not taken.
//  throughput is one byte per cycle unless a tlast byte is held (below); it is set by the
//  single scan step between the input register and the header walk registers.
//  a byte is held in the input register while the master word is stalled
//  and the held byte is itself a tlast word; other bytes keep flowing.
//  reset clears the scan state: before the first tuser word the latched
//  length is zero and nothing is found.
// ----------------------------------------------------------------------------
module avcc_nalu_keyframe_scanner
#(
    parameter int OFFSET_BITS = avcc_nks_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_byte[7:0], frame_length[27:8], zero pad
    input  logic        s_axis_tuser,   // first_byte
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // keyframe_found[0], keyframe_offset[20:1], remaining_length[40:21],
    // sps_found[41], sps_offset[61:42], zero pad
    output logic [63:0] m_axis_tdata
);

    localparam int RW = avcc_nks_pkg::RESULT_W;

    avcc_nks_pkg::item_t   in_item;
    avcc_nks_pkg::item_t   item;
    avcc_nks_pkg::result_t result;
    avcc_nks_pkg::result_t out_result;
    logic                  item_valid;
    logic                  advance;
    logic                  can_load;

    always_comb
    begin
        in_item.data_byte    = s_axis_tdata[7:0];
        in_item.frame_length = s_axis_tdata[27:8];
        in_item.first_byte   = s_axis_tuser;
        in_item.last_byte    = s_axis_tlast;
    end

    // only a last byte needs room in the result register
    assign advance = item_valid && (!item.last_byte || can_load);

    avcc_nks_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    avcc_nks_scan_core
    #(
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_scan_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .result (result)
    );

    avcc_nks_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && item.last_byte),
        .load_result (result),
        .can_load    (can_load),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    assign m_axis_tdata = {{(64 - RW){1'b0}}, out_result};

endmodule

@@ rtl/avcc_nks_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_nks_in_stage
// input register of the scanner, refilled in the same cycle it drains
// ----------------------------------------------------------------------------
module avcc_nks_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  avcc_nks_pkg::item_t  in_item,
    input  logic                 advance,
    output logic                 item_valid,
    output avcc_nks_pkg::item_t  item
);

    logic                valid_reg;
    logic                valid_next;
    avcc_nks_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/avcc_nks_scan_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_nks_scan_core
// header walk state and per-byte update, one byte per step
// ----------------------------------------------------------------------------
module avcc_nks_scan_core
#(
    parameter int OFFSET_BITS = avcc_nks_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  avcc_nks_pkg::item_t     item,
    output avcc_nks_pkg::result_t   result
);

    localparam int LW    = avcc_nks_pkg::LENGTH_W;
    localparam int WW    = avcc_nks_pkg::WINDOW_W;
    localparam int CMP_W = (OFFSET_BITS + 2 > WW + 2) ? OFFSET_BITS + 2 : WW + 2;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS:0]   HEADER_MAX = {(OFFSET_BITS + 1){1'b1}};

    logic [WW-1:0]          window_reg, window_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS:0]   header_reg, header_next;
    logic [LW-1:0]          length_reg, length_next;
    logic                   stopped_reg, stopped_next;
    logic                   idr_seen_reg, idr_seen_next;
    logic [LW-1:0]          idr_pos_reg, idr_pos_next;
    logic                   sps_seen_reg, sps_seen_next;
    logic [LW-1:0]          sps_pos_reg, sps_pos_next;

    logic [OFFSET_BITS-1:0] cur;
    logic [WW-1:0]          window_base;
    logic [OFFSET_BITS:0]   header_base;
    logic                   stopped_base;
    logic                   idr_seen_base;
    logic [LW-1:0]          idr_pos_base;
    logic                   sps_seen_base;
    logic [LW-1:0]          sps_pos_base;

    logic [CMP_W-1:0]       cur_w;
    logic [CMP_W-1:0]       header_w;
    logic [CMP_W-1:0]       length_w;
    logic [CMP_W-1:0]       len_w;
    logic [CMP_W-1:0]       next_w;
    logic                   at_header;
    logic                   past_end;
    logic [4:0]             nal_type;

    always_comb
    begin
        // a first byte restarts the scan from offset zero
        if (item.first_byte)
        begin
            cur           = '0;
            length_next   = item.frame_length;
            window_base   = '0;
            header_base   = '0;
            stopped_base  = 1'b0;
            idr_seen_base = 1'b0;
            idr_pos_base  = '0;
            sps_seen_base = 1'b0;
            sps_pos_base  = '0;
        end
        else
        begin
            cur           = offset_reg;
            length_next   = length_reg;
            window_base   = window_reg;
            header_base   = header_reg;
            stopped_base  = stopped_reg;
            idr_seen_base = idr_seen_reg;
            idr_pos_base  = idr_pos_reg;
            sps_seen_base = sps_seen_reg;
            sps_pos_base  = sps_pos_reg;
        end

        cur_w    = CMP_W'(cur);
        header_w = CMP_W'(header_base);
        length_w = CMP_W'(length_next);
        len_w    = CMP_W'(window_base);
        next_w   = header_w + len_w + CMP_W'(avcc_nks_pkg::PREFIX_BYTES);
        nal_type = item.data_byte[4:0];

        at_header = !stopped_base
                    && (cur_w == header_w + CMP_W'(avcc_nks_pkg::PREFIX_BYTES));
        past_end  = (cur == OFFSET_MAX) || (header_w >= length_w) || (cur_w >= length_w);

        header_next   = header_base;
        stopped_next  = stopped_base;
        idr_seen_next = idr_seen_base;
        idr_pos_next  = idr_pos_base;
        sps_seen_next = sps_seen_base;
        sps_pos_next  = sps_pos_base;

        if (at_header)
        begin
            if (past_end)
            begin
                stopped_next = 1'b1;
            end
            else if (nal_type == avcc_nks_pkg::NAL_TYPE_IDR)
            begin
                idr_seen_next = 1'b1;
                idr_pos_next  = header_w[LW-1:0];
                stopped_next  = 1'b1;
            end
            else
            begin
                if (nal_type == avcc_nks_pkg::NAL_TYPE_SPS)
                begin
                    sps_seen_next = 1'b1;
                    sps_pos_next  = header_w[LW-1:0];
                end
                if (len_w > length_w)
                begin
                    stopped_next = 1'b1;
                end
                else if (next_w > CMP_W'(HEADER_MAX))
                begin
                    header_next = HEADER_MAX;
                end
                else
                begin
                    header_next = next_w[OFFSET_BITS:0];
                end
            end
        end

        window_next = {window_base[WW-9:0], item.data_byte};
        offset_next = (cur == OFFSET_MAX) ? OFFSET_MAX : cur + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            offset_reg   <= '0;
            header_reg   <= '0;
            length_reg   <= '0;
            stopped_reg  <= 1'b0;
            idr_seen_reg <= 1'b0;
            idr_pos_reg  <= '0;
            sps_seen_reg <= 1'b0;
            sps_pos_reg  <= '0;
        end
        else if (step)
        begin
            window_reg   <= window_next;
            offset_reg   <= offset_next;
            header_reg   <= header_next;
            length_reg   <= length_next;
            stopped_reg  <= stopped_next;
            idr_seen_reg <= idr_seen_next;
            idr_pos_reg  <= idr_pos_next;
            sps_seen_reg <= sps_seen_next;
            sps_pos_reg  <= sps_pos_next;
        end
    end

    always_comb
    begin
        result.keyframe_found   = idr_seen_next;
        result.keyframe_offset  = idr_seen_next ? idr_pos_next : '0;
        result.remaining_length = idr_seen_next ? length_next - idr_pos_next : '0;
        result.sps_found        = sps_seen_next;
        result.sps_offset       = sps_seen_next ? sps_pos_next : '0;
    end

endmodule

@@ rtl/avcc_nks_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_nks_out_stage
// result register on the master side
// ----------------------------------------------------------------------------
module avcc_nks_out_stage
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  avcc_nks_pkg::result_t   load_result,
    output logic                    can_load,
    output logic                    out_valid,
    input  logic                    out_ready,
    output avcc_nks_pkg::result_t   out_result
);

    logic                  valid_reg;
    logic                  valid_next;
    avcc_nks_pkg::result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
